@@ hw/rtl/bounded_sequence_deque_defines.svh @@
// ----------------------------------------------------------------------------
// bounded_sequence_deque_defines
// assertion macros shared by the deque checker
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SEQUENCE_DEQUE_DEFINES_SVH
`define BOUNDED_SEQUENCE_DEQUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BSD_ASSERT_IMP(label, ant, con, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BSD_ASSERT_NXT(label, ant, con, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

@@ hw/rtl/bsd_pkg.sv @@
// ----------------------------------------------------------------------------
// bsd_pkg
// shared constants, command and status codes, memory request type
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsd_pkg;

  localparam int CAPACITY = 256;
  localparam int DATA_W   = 16;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = PTR_W + 1;

  typedef enum logic [3:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_INSERT_AT  = 4'd4,
    CMD_REMOVE_AT  = 4'd5,
    CMD_SEARCH     = 4'd6,
    CMD_REMOVE_VAL = 4'd7,
    CMD_CLEAR      = 4'd8
  } bsd_cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_NOT_FOUND = 3'd4
  } bsd_status_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } bsd_mem_req_t;

endpackage

@@ hw/rtl/bsd_ram.sv @@
// ----------------------------------------------------------------------------
// bsd_ram
// simple dual-port ram, one write and one read port, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsd_ram #(
  parameter int ADDR_W = 8,
  parameter int WORD_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [2**ADDR_W];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/bsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsd_ctrl
// command sequencer: pointers, count, shift and search walks over the ring
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsd_ctrl
  import bsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_cmd,
  input  logic [DATA_W-1:0]  in_item_value,
  input  logic [CNT_W-1:0]   in_index,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [DATA_W-1:0]  out_value,
  output logic [PTR_W-1:0]   out_found_index,
  output logic [CNT_W-1:0]   out_count,
  output bsd_mem_req_t       mem_req,
  input  logic [DATA_W-1:0]  mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_INSERT,
    S_REMOVE,
    S_SEARCH
  } state_t;

  state_t             state_r, state_nxt;
  bsd_cmd_t           cmd_r, cmd_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rpos_r, rpos_nxt;
  logic [CNT_W-1:0]   wpos_r, wpos_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic               pend_r, pend_nxt;
  logic               first_r, first_nxt;
  logic [DATA_W-1:0]  oval_r, oval_nxt;
  logic [PTR_W-1:0]   found_r, found_nxt;
  logic               ovalid_r, ovalid_nxt;
  bsd_status_t        ostatus_r, ostatus_nxt;
  logic [DATA_W-1:0]  ovalue_r, ovalue_nxt;
  logic [PTR_W-1:0]   ofound_r, ofound_nxt;

  logic               done;
  bsd_status_t        res_status;
  logic [DATA_W-1:0]  res_value;
  logic [PTR_W-1:0]   res_found;
  logic               full;
  logic               hit;

  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] head,
                                            input logic [CNT_W-1:0] pos);
    return head + pos[PTR_W-1:0];
  endfunction

  assign full = (count_r == CNT_W'(CAPACITY));
  assign hit  = pend_r && (mem_rdata == val_r);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    rpos_nxt   = rpos_r;
    wpos_nxt   = wpos_r;
    rem_nxt    = rem_r;
    pend_nxt   = pend_r;
    first_nxt  = first_r;
    oval_nxt   = oval_r;
    found_nxt  = found_r;
    mem_req    = '0;
    done       = 1'b0;
    res_status = ST_OK;
    res_value  = '0;
    res_found  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = bsd_cmd_t'(in_cmd);
          val_nxt   = in_item_value;
          idx_nxt   = in_index;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (cmd_r)
          CMD_PUSH_FRONT: begin
            done = 1'b1;
            if (full) begin
              res_status = ST_FULL;
            end else begin
              head_nxt      = head_r - PTR_W'(1);
              mem_req.we    = 1'b1;
              mem_req.waddr = head_r - PTR_W'(1);
              mem_req.wdata = val_r;
              count_nxt     = count_r + CNT_W'(1);
            end
          end
          CMD_PUSH_BACK: begin
            done = 1'b1;
            if (full) begin
              res_status = ST_FULL;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = slot(head_r, count_r);
              mem_req.wdata = val_r;
              count_nxt     = count_r + CNT_W'(1);
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            if (count_r == '0) begin
              done       = 1'b1;
              res_status = ST_EMPTY;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = (cmd_r == CMD_POP_FRONT) ? head_r
                                                       : slot(head_r, count_r - CNT_W'(1));
              state_nxt     = S_POP;
            end
          end
          CMD_INSERT_AT: begin
            if (idx_r > count_r) begin
              done       = 1'b1;
              res_status = ST_BAD_INDEX;
            end else if (full) begin
              done       = 1'b1;
              res_status = ST_FULL;
            end else begin
              rem_nxt   = count_r - idx_r;
              rpos_nxt  = count_r - CNT_W'(1);
              pend_nxt  = 1'b0;
              state_nxt = S_INSERT;
            end
          end
          CMD_REMOVE_AT: begin
            if (idx_r >= count_r) begin
              done       = 1'b1;
              res_status = ST_BAD_INDEX;
            end else begin
              rem_nxt   = count_r - idx_r;
              rpos_nxt  = idx_r;
              pend_nxt  = 1'b0;
              state_nxt = S_REMOVE;
            end
          end
          CMD_SEARCH, CMD_REMOVE_VAL: begin
            if (count_r == '0) begin
              done       = 1'b1;
              res_status = ST_NOT_FOUND;
            end else begin
              rem_nxt   = count_r;
              rpos_nxt  = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SEARCH;
            end
          end
          CMD_CLEAR: begin
            done      = 1'b1;
            head_nxt  = '0;
            count_nxt = '0;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end

      S_POP: begin
        done      = 1'b1;
        res_value = mem_rdata;
        count_nxt = count_r - CNT_W'(1);
        if (cmd_r == CMD_POP_FRONT) begin
          head_nxt = head_r + PTR_W'(1);
        end
      end

      // walk from the back toward index, each word moves up one place
      S_INSERT: begin
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = slot(head_r, wpos_r);
          mem_req.wdata = mem_rdata;
        end
        if (rem_r != '0) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = slot(head_r, rpos_r);
          wpos_nxt      = rpos_r + CNT_W'(1);
          rpos_nxt      = rpos_r - CNT_W'(1);
          rem_nxt       = rem_r - CNT_W'(1);
          pend_nxt      = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = slot(head_r, idx_r);
            mem_req.wdata = val_r;
            count_nxt     = count_r + CNT_W'(1);
            done          = 1'b1;
          end
        end
      end

      // first word read is the removed one, the rest move down one place
      S_REMOVE: begin
        if (pend_r) begin
          if (first_r) begin
            oval_nxt = mem_rdata;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = slot(head_r, wpos_r);
            mem_req.wdata = mem_rdata;
          end
        end
        if (rem_r != '0) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = slot(head_r, rpos_r);
          wpos_nxt      = rpos_r - CNT_W'(1);
          first_nxt     = (rpos_r == idx_r);
          rpos_nxt      = rpos_r + CNT_W'(1);
          rem_nxt       = rem_r - CNT_W'(1);
          pend_nxt      = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          done      = 1'b1;
          count_nxt = count_r - CNT_W'(1);
          res_value = (pend_r && first_r) ? mem_rdata : oval_r;
          if (cmd_r == CMD_REMOVE_VAL) begin
            res_found = found_r;
          end
        end
      end

      S_SEARCH: begin
        if (hit) begin
          found_nxt = wpos_r[PTR_W-1:0];
          if (cmd_r == CMD_SEARCH) begin
            done      = 1'b1;
            res_found = wpos_r[PTR_W-1:0];
          end else begin
            idx_nxt   = wpos_r;
            rpos_nxt  = wpos_r;
            rem_nxt   = count_r - wpos_r;
            pend_nxt  = 1'b0;
            state_nxt = S_REMOVE;
          end
        end else if (rem_r != '0) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = slot(head_r, rpos_r);
          wpos_nxt      = rpos_r;
          rpos_nxt      = rpos_r + CNT_W'(1);
          rem_nxt       = rem_r - CNT_W'(1);
          pend_nxt      = 1'b1;
        end else begin
          done       = 1'b1;
          res_status = ST_NOT_FOUND;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      state_nxt = S_IDLE;
    end
    ovalid_nxt  = done;
    ostatus_nxt = done ? res_status : ostatus_r;
    ovalue_nxt  = done ? res_value : ovalue_r;
    ofound_nxt  = done ? res_found : ofound_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
    cmd_r     <= cmd_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    rpos_r    <= rpos_nxt;
    wpos_r    <= wpos_nxt;
    rem_r     <= rem_nxt;
    first_r   <= first_nxt;
    oval_r    <= oval_nxt;
    found_r   <= found_nxt;
    ostatus_r <= ostatus_nxt;
    ovalue_r  <= ovalue_nxt;
    ofound_r  <= ofound_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ovalid_r;
  assign out_status      = ostatus_r;
  assign out_value       = ovalue_r;
  assign out_found_index = ofound_r;
  assign out_count       = count_r;

endmodule

@@ hw/rtl/bounded_sequence_deque.sv @@
// ----------------------------------------------------------------------------
// bounded_sequence_deque
// bounded deque of 16-bit words with positional insert, remove and search
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result shows on
// the out_ ports for exactly one cycle with out_valid high and cannot be held
// off, so capture it in that cycle. The words live in one ring memory with a
// single read and a single write port and a registered read, and that port
// sets the pace of each command: push writes once, clear resets the pointers,
// pop reads once, insert at and remove at shift the words between the index
// and the back one place, search reads from the front until a match or the
// end, and remove value searches and then shifts the rest down. Failed
// commands (empty, full, bad index) end in decode without touching the memory.
// No clearing pass follows reset; the block takes commands at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_sequence_deque
  import bsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_cmd,
  input  logic [DATA_W-1:0]  in_item_value,
  input  logic [CNT_W-1:0]   in_index,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [DATA_W-1:0]  out_value,
  output logic [PTR_W-1:0]   out_found_index,
  output logic [CNT_W-1:0]   out_count
);

  bsd_mem_req_t      mem_req;
  logic [DATA_W-1:0] mem_rdata;

  bsd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_item_value   (in_item_value),
    .in_index        (in_index),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_found_index (out_found_index),
    .out_count       (out_count),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata)
  );

  bsd_ram #(
    .ADDR_W (PTR_W),
    .WORD_W (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ hw/rtl/bsd_checker.sv @@
// ----------------------------------------------------------------------------
// bsd_checker
// port-level checks on the deque, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_sequence_deque_defines.svh"

module bsd_checker
  import bsd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [2:0]        out_status,
  input logic [DATA_W-1:0] out_value,
  input logic [CNT_W-1:0]  out_count
);

  logic res_empty;
  logic res_failed;

  assign res_empty  = out_valid && (out_status == ST_EMPTY);
  assign res_failed = out_valid && (out_status != ST_OK);

  `BSD_ASSERT_IMP(a_result_when_idle, out_valid, !busy, "result word while busy")
  `BSD_ASSERT_NXT(a_accept_goes_busy, start && !busy, busy, "accepted word did not start work")
  `BSD_ASSERT_IMP(a_count_in_range, out_valid, out_count <= CNT_W'(CAPACITY), "count too high")
  `BSD_ASSERT_IMP(a_empty_means_zero, res_empty, out_count == '0, "empty status with words")
  `BSD_ASSERT_IMP(a_fail_no_value, res_failed, out_value == '0, "failed word carries a value")

endmodule

bind bounded_sequence_deque bsd_checker u_bsd_checker (.*);
